/* rtl/core/vtp_pkg.sv */
// Shared types, constants and helpers for the vertex transform and projection block.
`default_nettype none

package vtp_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_OFFSET_X = 3'd0;
   localparam logic [2:0] REG_OFFSET_Y = 3'd1;
   localparam logic [2:0] REG_OFFSET_Z = 3'd2;
   localparam logic [2:0] REG_ANGLE_X  = 3'd3;
   localparam logic [2:0] REG_ANGLE_Y  = 3'd4;
   localparam logic [2:0] REG_ANGLE_Z  = 3'd5;
   localparam logic [2:0] REG_EYE      = 3'd6;

   localparam logic [30:0]        EYE_RESET = 31'd16777216;
   localparam logic signed [31:0] Q_ONE     = 32'sd65536;
   localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;

   // dividend magnitude bits of the projection divider
   localparam int DIV_BITS = 62;

   localparam int                 CORDIC_STEPS = 16;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

   // word fields that ride along the divider unchanged
   typedef struct packed {
      logic signed [31:0] depth;
      logic signed [31:0] u;
      logic signed [31:0] v;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] val);
      logic signed [31:0] res;
      if (val > 66'sd2147483647) begin
         res = Q_MAX;
      end else if (val < -66'sd2147483648) begin
         res = Q_MIN;
      end else begin
         res = val[31:0];
      end
      return res;
   endfunction

   // atan(2^-i) in Q2.30 binary angle units
   function automatic logic [29:0] arc(input logic [3:0] idx);
      logic [29:0] res;
      case (idx)
         4'd0:    res = 30'd536870912;
         4'd1:    res = 30'd316933406;
         4'd2:    res = 30'd167458907;
         4'd3:    res = 30'd85004756;
         4'd4:    res = 30'd42667331;
         4'd5:    res = 30'd21354465;
         4'd6:    res = 30'd10679838;
         4'd7:    res = 30'd5340245;
         4'd8:    res = 30'd2670163;
         4'd9:    res = 30'd1335087;
         4'd10:   res = 30'd667544;
         4'd11:   res = 30'd333772;
         4'd12:   res = 30'd166886;
         4'd13:   res = 30'd83443;
         4'd14:   res = 30'd41722;
         4'd15:   res = 30'd20861;
         default: res = 30'd0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/vtp_matrix.sv */
// Rotation matrix builder: three CORDIC units and a short multiply sequencer.
`default_nettype none

module vtp_matrix (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [15:0]        angle_x,
   input  wire logic [15:0]        angle_y,
   input  wire logic [15:0]        angle_z,
   output logic                    busy,
   output logic signed [31:0]      mtx [0:8]
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_CORD = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_MUL1 = 3'd4;
   localparam logic [2:0] ST_MUL2 = 3'd5;
   localparam logic [2:0] ST_SUM  = 3'd6;

   localparam int CORDIC_STEPS_M1 = vtp_pkg::CORDIC_STEPS - 1;

   logic [2:0] state_ff, state_in;
   logic [3:0] cnt_ff;

   // per axis: 0 = x, 1 = y, 2 = z
   logic signed [33:0] cx_ff [0:2];
   logic signed [33:0] cy_ff [0:2];
   logic signed [32:0] cz_ff [0:2];
   logic               flip_ff [0:2];
   logic signed [18:0] sin_ff [0:2];
   logic signed [18:0] cos_ff [0:2];

   // pair products: czcy czsy szcx szsx szcy szsy czcx czsx cysx cycx
   logic signed [37:0] p_ff [0:9];
   // triple products: czsy*sx czsy*cx szsy*sx szsy*cx
   logic signed [56:0] t_ff [0:3];

   logic [15:0] ang [0:2];

   assign ang[0] = angle_x;
   assign ang[1] = angle_y;
   assign ang[2] = angle_z;
   assign busy   = (state_ff != ST_IDLE);

   function automatic logic signed [31:0] rnd(input logic signed [63:0] val);
      logic signed [63:0] tmp;
      tmp = (val + 64'sh8000_0000) >>> 32;
      return tmp[31:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: state_in = ST_IDLE;
         ST_LOAD: state_in = ST_CORD;
         ST_CORD: state_in = (cnt_ff == 4'(CORDIC_STEPS_M1)) ? ST_FIN : ST_CORD;
         ST_FIN:  state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (start) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == ST_CORD) ? cnt_ff + 4'd1 : 4'd0;
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_cordic
      logic [31:0]        ain;
      logic [31:0]        aturn;
      logic               fl;
      logic signed [33:0] dx, dy, xf, yf, cr, sr;
      logic signed [32:0] arcs;

      always_comb begin
         ain   = {ang[a], 16'h0000};
         aturn = ain + 32'h4000_0000;
         fl    = aturn[31];
         dx    = cy_ff[a] >>> cnt_ff;
         dy    = cx_ff[a] >>> cnt_ff;
         arcs  = 33'(vtp_pkg::arc(cnt_ff));
         xf    = flip_ff[a] ? -cx_ff[a] : cx_ff[a];
         yf    = flip_ff[a] ? -cy_ff[a] : cy_ff[a];
         cr    = (xf + 34'sd8192) >>> 14;
         sr    = (yf + 34'sd8192) >>> 14;
      end

      always_ff @(posedge clock) begin
         case (state_ff)
            ST_LOAD: begin
               flip_ff[a] <= fl;
               cx_ff[a]   <= vtp_pkg::CORDIC_GAIN;
               cy_ff[a]   <= '0;
               cz_ff[a]   <= fl ? 33'(signed'(ain - 32'h8000_0000))
                                : 33'(signed'(ain));
            end
            ST_CORD: begin
               if (!cz_ff[a][32]) begin
                  cx_ff[a] <= cx_ff[a] - dx;
                  cy_ff[a] <= cy_ff[a] + dy;
                  cz_ff[a] <= cz_ff[a] - arcs;
               end else begin
                  cx_ff[a] <= cx_ff[a] + dx;
                  cy_ff[a] <= cy_ff[a] - dy;
                  cz_ff[a] <= cz_ff[a] + arcs;
               end
            end
            ST_FIN: begin
               cos_ff[a] <= cr[18:0];
               sin_ff[a] <= sr[18:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            mtx[k] <= (k % 4 == 0) ? vtp_pkg::Q_ONE : '0;
         end
      end else begin
         case (state_ff)
            ST_MUL1: begin
               p_ff[0] <= cos_ff[2] * cos_ff[1];
               p_ff[1] <= cos_ff[2] * sin_ff[1];
               p_ff[2] <= sin_ff[2] * cos_ff[0];
               p_ff[3] <= sin_ff[2] * sin_ff[0];
               p_ff[4] <= sin_ff[2] * cos_ff[1];
               p_ff[5] <= sin_ff[2] * sin_ff[1];
               p_ff[6] <= cos_ff[2] * cos_ff[0];
               p_ff[7] <= cos_ff[2] * sin_ff[0];
               p_ff[8] <= cos_ff[1] * sin_ff[0];
               p_ff[9] <= cos_ff[1] * cos_ff[0];
            end
            ST_MUL2: begin
               t_ff[0] <= p_ff[1] * sin_ff[0];
               t_ff[1] <= p_ff[1] * cos_ff[0];
               t_ff[2] <= p_ff[5] * sin_ff[0];
               t_ff[3] <= p_ff[5] * cos_ff[0];
            end
            ST_SUM: begin
               mtx[0] <= rnd(64'(p_ff[0]) <<< 16);
               mtx[1] <= rnd(64'(t_ff[0]) - (64'(p_ff[2]) <<< 16));
               mtx[2] <= rnd(64'(t_ff[1]) + (64'(p_ff[3]) <<< 16));
               mtx[3] <= rnd(64'(p_ff[4]) <<< 16);
               mtx[4] <= rnd(64'(t_ff[2]) + (64'(p_ff[6]) <<< 16));
               mtx[5] <= rnd(64'(t_ff[3]) - (64'(p_ff[7]) <<< 16));
               mtx[6] <= rnd(-(64'(sin_ff[1]) <<< 32));
               mtx[7] <= rnd(64'(p_ff[8]) <<< 16);
               mtx[8] <= rnd(64'(p_ff[9]) <<< 16);
            end
            default: begin
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_done_after_sum: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> ($past(state_ff) == ST_SUM))
      else $error("matrix builder left busy without writing the matrix");
`endif

endmodule

`default_nettype wire

/* rtl/core/vtp_proj.sv */
// Pipelined projection divider: one quotient bit per stage for x and y.
`default_nettype none

module vtp_proj (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic signed [63:0]  in_num_x,
   input  wire logic signed [63:0]  in_num_y,
   input  wire logic signed [33:0]  in_den,
   input  wire logic                in_rx_neg,
   input  wire logic                in_rx_nz,
   input  wire logic                in_ry_neg,
   input  wire logic                in_ry_nz,
   input  wire vtp_pkg::side_type   in_side,
   output logic                     out_valid,
   output logic signed [31:0]       out_px,
   output logic signed [31:0]       out_py,
   output logic                     out_fault,
   output vtp_pkg::side_type        out_side
);

   localparam int NB = vtp_pkg::DIV_BITS;

   typedef struct packed {
      logic              valid;
      logic [32:0]       rem_x;
      logic [32:0]       rem_y;
      logic [NB-1:0]     nq_x;
      logic [NB-1:0]     nq_y;
      logic [32:0]       dv;
      logic              qneg_x;
      logic              qneg_y;
      logic              fault;
      logic              rx_neg;
      logic              rx_nz;
      logic              ry_neg;
      logic              ry_nz;
      vtp_pkg::side_type side;
   } stage_type;

   stage_type stg_ff [0:NB];
   stage_type stg_in [0:NB];

   logic signed [63:0] mag_x, mag_y;
   logic signed [33:0] mag_d;

   function automatic logic signed [31:0] fix(input logic [NB-1:0] q, input logic qneg,
                                              input logic fault, input logic rneg,
                                              input logic rnz);
      logic signed [31:0] res;
      if (fault) begin
         res = rneg ? vtp_pkg::Q_MIN : (rnz ? vtp_pkg::Q_MAX : '0);
      end else if (qneg) begin
         res = (q > NB'(64'h8000_0000)) ? vtp_pkg::Q_MIN : -signed'(q[31:0]);
      end else begin
         res = (q > NB'(64'h7FFF_FFFF)) ? vtp_pkg::Q_MAX : signed'(q[31:0]);
      end
      return res;
   endfunction

   // entry: magnitudes, quotient signs, zero denominator
   always_comb begin
      mag_x            = in_num_x[63] ? -in_num_x : in_num_x;
      mag_y            = in_num_y[63] ? -in_num_y : in_num_y;
      mag_d            = in_den[33] ? -in_den : in_den;
      stg_in[0].valid  = in_valid;
      stg_in[0].rem_x  = '0;
      stg_in[0].rem_y  = '0;
      stg_in[0].nq_x   = mag_x[NB-1:0];
      stg_in[0].nq_y   = mag_y[NB-1:0];
      stg_in[0].dv     = mag_d[32:0];
      stg_in[0].qneg_x = in_num_x[63] ^ in_den[33];
      stg_in[0].qneg_y = in_num_y[63] ^ in_den[33];
      stg_in[0].fault  = (in_den == '0);
      stg_in[0].rx_neg = in_rx_neg;
      stg_in[0].rx_nz  = in_rx_nz;
      stg_in[0].ry_neg = in_ry_neg;
      stg_in[0].ry_nz  = in_ry_nz;
      stg_in[0].side   = in_side;
   end

   for (genvar k = 1; k <= NB; k++) begin : g_stage
      logic [33:0] shx, shy;
      logic        gex, gey;

      always_comb begin
         stg_in[k]       = stg_ff[k-1];
         shx             = {stg_ff[k-1].rem_x, stg_ff[k-1].nq_x[NB-1]};
         shy             = {stg_ff[k-1].rem_y, stg_ff[k-1].nq_y[NB-1]};
         gex             = shx >= {1'b0, stg_ff[k-1].dv};
         gey             = shy >= {1'b0, stg_ff[k-1].dv};
         stg_in[k].rem_x = gex ? 33'(shx - {1'b0, stg_ff[k-1].dv}) : shx[32:0];
         stg_in[k].rem_y = gey ? 33'(shy - {1'b0, stg_ff[k-1].dv}) : shy[32:0];
         stg_in[k].nq_x  = {stg_ff[k-1].nq_x[NB-2:0], gex};
         stg_in[k].nq_y  = {stg_ff[k-1].nq_y[NB-2:0], gey};
      end
   end

   for (genvar k = 0; k <= NB; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k] <= '0;
         end else if (en) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= stg_ff[NB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_px    <= fix(stg_ff[NB].nq_x, stg_ff[NB].qneg_x, stg_ff[NB].fault,
                          stg_ff[NB].rx_neg, stg_ff[NB].rx_nz);
         out_py    <= fix(stg_ff[NB].nq_y, stg_ff[NB].qneg_y, stg_ff[NB].fault,
                          stg_ff[NB].ry_neg, stg_ff[NB].ry_nz);
         out_fault <= stg_ff[NB].fault;
         out_side  <= stg_ff[NB].side;
      end
   end

`ifndef ASSERT_OFF
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (stg_ff[NB].valid && !stg_ff[NB].fault) |->
         (stg_ff[NB].rem_x < stg_ff[NB].dv && stg_ff[NB].rem_y < stg_ff[NB].dv))
      else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

/* rtl/core/vertex_transform_project.sv */
// Throughput: one word per cycle while req_stall is low; the 62-stage restoring
// divider is fully pipelined.
// A write to an angle register starts the matrix builder (LOAD, CORD, FIN, MUL1,
// MUL2 and SUM states); req_stall is high in the write cycle and while the
// builder runs.
// Reset (synchronous): pipeline empties, registers take their reset values and
// the rotation matrix is the exact identity.
`default_nettype none

module vertex_transform_project #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input vertex words
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_in_x,
   input  wire logic signed [31:0] req_in_y,
   input  wire logic signed [31:0] req_in_z,
   input  wire logic signed [31:0] req_in_u,
   input  wire logic signed [31:0] req_in_v,
   // projected vertex words
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_screen_x,
   output logic signed [31:0]      rsp_screen_y,
   output logic signed [31:0]      rsp_depth_z,
   output logic signed [31:0]      rsp_out_u,
   output logic signed [31:0]      rsp_out_v,
   output logic                    rsp_divide_fault,
   // configuration writes
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   // screen center in Q16.16, whole pixels
   localparam logic signed [31:0] CENTER_X = 32'((SCREEN_WIDTH / 2) * 65536);
   localparam logic signed [31:0] CENTER_Y = 32'((SCREEN_HEIGHT / 2) * 65536);

   // ---------------- configuration registers ----------------
   logic signed [31:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic [15:0]        angle_x_ff, angle_y_ff, angle_z_ff;
   logic [30:0]        eye_ff;
   logic               angle_wr;

   assign angle_wr = csr_wr_en && (csr_index == vtp_pkg::REG_ANGLE_X ||
                                   csr_index == vtp_pkg::REG_ANGLE_Y ||
                                   csr_index == vtp_pkg::REG_ANGLE_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
         angle_x_ff  <= '0;
         angle_y_ff  <= '0;
         angle_z_ff  <= '0;
         eye_ff      <= vtp_pkg::EYE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            vtp_pkg::REG_OFFSET_X: offset_x_ff <= csr_wdata;
            vtp_pkg::REG_OFFSET_Y: offset_y_ff <= csr_wdata;
            vtp_pkg::REG_OFFSET_Z: offset_z_ff <= csr_wdata;
            vtp_pkg::REG_ANGLE_X:  angle_x_ff  <= csr_wdata[15:0];
            vtp_pkg::REG_ANGLE_Y:  angle_y_ff  <= csr_wdata[15:0];
            vtp_pkg::REG_ANGLE_Z:  angle_z_ff  <= csr_wdata[15:0];
            vtp_pkg::REG_EYE:      eye_ff      <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- rotation matrix ----------------
   logic               mtx_busy;
   logic signed [31:0] mtx [0:8];

   vtp_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .start   (angle_wr),
      .angle_x (angle_x_ff),
      .angle_y (angle_y_ff),
      .angle_z (angle_z_ff),
      .busy    (mtx_busy),
      .mtx     (mtx)
   );

   // ---------------- flow control ----------------
   // The whole pipe advances together; it only halts when the output
   // register holds a word that the consumer is stalling.
   logic en, accept;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en || mtx_busy || angle_wr;
   assign accept    = req_valid && !req_stall;

   // stage A: translate with saturation
   logic               a_valid_ff;
   logic signed [31:0] a_t_ff [0:2];
   logic signed [31:0] a_u_ff, a_v_ff;

   // stage B: nine products
   logic               b_valid_ff;
   logic signed [63:0] b_prod_ff [0:8];
   logic signed [31:0] b_u_ff, b_v_ff;

   // stage C: row sums
   logic               c_valid_ff;
   logic signed [65:0] c_acc_ff [0:2];
   logic signed [31:0] c_u_ff, c_v_ff;

   // stage D: round to Q16.16 and saturate
   logic               d_valid_ff;
   logic signed [31:0] d_r_ff [0:2];
   logic signed [31:0] d_u_ff, d_v_ff;

   // stage E: numerators and denominator
   logic               e_valid_ff;
   logic signed [63:0] e_num_x_ff, e_num_y_ff;
   logic signed [33:0] e_den_ff;
   logic               e_rx_neg_ff, e_rx_nz_ff, e_ry_neg_ff, e_ry_nz_ff;
   vtp_pkg::side_type  e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_t_ff[0] <= vtp_pkg::sat32(66'(req_in_x) + 66'(offset_x_ff));
         a_t_ff[1] <= vtp_pkg::sat32(66'(req_in_y) + 66'(offset_y_ff));
         a_t_ff[2] <= vtp_pkg::sat32(66'(req_in_z) + 66'(offset_z_ff));
         a_u_ff    <= req_in_u;
         a_v_ff    <= req_in_v;

         for (int k = 0; k < 9; k++) begin
            b_prod_ff[k] <= mtx[k] * a_t_ff[k % 3];
         end
         b_u_ff <= a_u_ff;
         b_v_ff <= a_v_ff;

         for (int i = 0; i < 3; i++) begin
            c_acc_ff[i] <= 66'(b_prod_ff[3*i]) + 66'(b_prod_ff[3*i+1])
                         + 66'(b_prod_ff[3*i+2]);
         end
         c_u_ff <= b_u_ff;
         c_v_ff <= b_v_ff;

         for (int i = 0; i < 3; i++) begin
            d_r_ff[i] <= vtp_pkg::sat32((c_acc_ff[i] + 66'sd32768) >>> 16);
         end
         d_u_ff <= c_u_ff;
         d_v_ff <= c_v_ff;

         e_num_x_ff      <= d_r_ff[0] * signed'({1'b0, eye_ff});
         e_num_y_ff      <= d_r_ff[1] * signed'({1'b0, eye_ff});
         e_den_ff        <= 34'(d_r_ff[2]) + 34'(signed'({1'b0, eye_ff}));
         e_rx_neg_ff     <= d_r_ff[0][31];
         e_rx_nz_ff      <= (d_r_ff[0] != '0);
         e_ry_neg_ff     <= d_r_ff[1][31];
         e_ry_nz_ff      <= (d_r_ff[1] != '0);
         e_side_ff.depth <= d_r_ff[2];
         e_side_ff.u     <= d_u_ff;
         e_side_ff.v     <= d_v_ff;
      end
   end

   // ---------------- projection divide ----------------
   logic               p_valid;
   logic signed [31:0] p_px, p_py;
   logic               p_fault;
   vtp_pkg::side_type  p_side;

   vtp_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .in_num_x  (e_num_x_ff),
      .in_num_y  (e_num_y_ff),
      .in_den    (e_den_ff),
      .in_rx_neg (e_rx_neg_ff),
      .in_rx_nz  (e_rx_nz_ff),
      .in_ry_neg (e_ry_neg_ff),
      .in_ry_nz  (e_ry_nz_ff),
      .in_side   (e_side_ff),
      .out_valid (p_valid),
      .out_px    (p_px),
      .out_py    (p_py),
      .out_fault (p_fault),
      .out_side  (p_side)
   );

   // ---------------- centering and output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (en) begin
         rsp_valid <= p_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_screen_x     <= vtp_pkg::sat32(66'(p_px) + 66'(CENTER_X));
         rsp_screen_y     <= vtp_pkg::sat32(66'(p_py) + 66'(CENTER_Y));
         rsp_depth_z      <= p_side.depth;
         rsp_out_u        <= p_side.u;
         rsp_out_v        <= p_side.v;
         rsp_divide_fault <= p_fault;
      end
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !mtx_busy)
      else $error("vertex word accepted while the matrix is being rebuilt");

   a_hold_front: assert property (@(posedge clock) disable iff (reset)
      (!en && !req_stall) |-> 1'b0)
      else $error("input open while the pipe is halted");

   a_halt_keeps_stage: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(a_valid_ff) && $stable(e_valid_ff))
      else $error("pipeline moved during a halt");
`endif

endmodule

`default_nettype wire
